// ===== rtl/linear_probe_hash_set_core_assert.svh =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core_assert.svh
// Assertion macros used by the hash set core.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lphs_pkg.sv =====
// ----------------------------------------------------------------------------
// lphs_pkg
// Types and constants of the linear probing hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int KEY_W      = 64;
  localparam int FUNC_W     = 2;
  localparam int CNT_W      = 10;
  localparam int SIZE_W     = 4;
  localparam int LIMIT_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int OUT_W      = 16;

  // Operation codes carried on s_tuser
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXISTS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT = 2'd1;

  localparam logic [SIZE_W-1:0]  SIZE_LOG2_RST  = 4'd10;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 10'd716;
  localparam logic [4:0]         SIZE_LOG2_MIN  = 5'd4;

  // Mix sequence
  localparam int MIX_STEPS  = 9;
  localparam int MIX_STEP_W = 4;

  // One step of the shared mix unit: acc <= A op (B shifted)
  typedef struct packed {
    logic       inv_a;     // A is ~acc instead of acc
    logic       use_base;  // B is the saved value instead of acc
    logic       shr;       // logical right shift, else left shift
    logic       op_xor;    // xor, else add
    logic [4:0] sh;        // shift amount
  } mix_op_t;

  // Status of the mix unit
  typedef struct packed {
    logic busy;
    logic done;
  } mix_stat_t;

  // Shift-add-xor mix as a sequence of single-operation steps
  function automatic mix_op_t mix_step(input logic [MIX_STEP_W-1:0] step);
    mix_op_t op;
    op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b0, op_xor: 1'b0, sh: 5'd0};
    case (step)
      4'd0: op = '{inv_a: 1'b1, use_base: 1'b0, shr: 1'b0, op_xor: 1'b0, sh: 5'd21};
      4'd1: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b1, op_xor: 1'b1, sh: 5'd24};
      4'd2: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b0, op_xor: 1'b0, sh: 5'd3};
      4'd3: op = '{inv_a: 1'b0, use_base: 1'b1, shr: 1'b0, op_xor: 1'b0, sh: 5'd8};
      4'd4: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b1, op_xor: 1'b1, sh: 5'd14};
      4'd5: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b0, op_xor: 1'b0, sh: 5'd2};
      4'd6: op = '{inv_a: 1'b0, use_base: 1'b1, shr: 1'b0, op_xor: 1'b0, sh: 5'd4};
      4'd7: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b1, op_xor: 1'b1, sh: 5'd28};
      4'd8: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b0, op_xor: 1'b0, sh: 5'd31};
      default: op = '{inv_a: 1'b0, use_base: 1'b0, shr: 1'b0, op_xor: 1'b0, sh: 5'd0};
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/lphs_ram.sv =====
// ----------------------------------------------------------------------------
// lphs_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write at addr, register the read of addr
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/lphs_mix.sv =====
// ----------------------------------------------------------------------------
// lphs_mix
// Shared add/xor/shift unit that runs the 64-bit key mix over nine steps.
// ----------------------------------------------------------------------------
module lphs_mix (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lphs_pkg::KEY_W-1:0] key,
  output lphs_pkg::mix_stat_t      stat,
  output logic [lphs_pkg::KEY_W-1:0] hash
);

  logic [lphs_pkg::KEY_W-1:0]      acc;
  logic [lphs_pkg::KEY_W-1:0]      base;
  logic [lphs_pkg::MIX_STEP_W-1:0] step;
  logic                            busy;
  logic                            done;

  lphs_pkg::mix_op_t               op;
  logic [lphs_pkg::KEY_W-1:0]      opa;
  logic [lphs_pkg::KEY_W-1:0]      opb;
  logic [lphs_pkg::KEY_W-1:0]      opb_sh;
  logic [lphs_pkg::KEY_W-1:0]      acc_next;

  // Operand select, shift and the one add/xor
  always_comb begin
    op       = lphs_pkg::mix_step(step);
    opa      = op.inv_a ? ~acc : acc;
    opb      = op.use_base ? base : acc;
    opb_sh   = op.shr ? (opb >> op.sh) : (opb << op.sh);
    acc_next = op.op_xor ? (opa ^ opb_sh) : (opa + opb_sh);
  end

  // Step sequencer; base keeps the value from before the previous step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == lphs_pkg::MIX_STEP_W'(lphs_pkg::MIX_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= key;
    end else if (busy) begin
      acc  <= acc_next;
      base <= acc;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign hash      = acc;

endmodule

// ===== rtl/linear_probe_hash_set_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_set_core
// Set of 64-bit keys in an open-addressed table with linear probing.
//
// s_tuser carries the operation (insert, exists, clear), s_tdata the key.
// One result per operation leaves on m_tdata: present, status, count.
// Configuration writes (size_log2, load_limit) go over cfg_valid/cfg_ready
// and are taken in any cycle; write them only while the block is idle.
// One operation is in flight at a time; s_tready is high only when idle.
// Insert and exists first run the nine-step mix in the shared add/xor unit,
// then read the table RAM once per probed slot; a new key is then written
// in a state of its own. Clear sweeps all MAX_SLOTS entries, one per cycle.
// After reset the same sweep runs before s_tready rises.
// A finished result waits in the output register while m_tready is low;
// the next operation may be accepted meanwhile and waits for that register.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_core_assert.svh"

module linear_probe_hash_set_core #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lphs_pkg::KEY_W-1:0]          s_tdata,   // [63:0] key
  input  logic [lphs_pkg::FUNC_W-1:0]         s_tuser,   // [1:0] func
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lphs_pkg::OUT_W-1:0]          m_tdata,   // [0] present, [1] status,
                                                         // [11:2] count, [15:12] zero
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lphs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lphs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int LIM_W  = (SLOT_W > lphs_pkg::LIMIT_W) ? SLOT_W : lphs_pkg::LIMIT_W;
  localparam int RAM_W  = lphs_pkg::KEY_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_RD,
    ST_CMP,
    ST_WRITE,
    ST_RESP
  } state_t;

  state_t                          state;
  logic [SLOT_W-1:0]               sweep;
  logic                            clear_op;
  logic [lphs_pkg::FUNC_W-1:0]     func_q;
  logic [lphs_pkg::KEY_W-1:0]      key_q;
  logic [SLOT_W-1:0]               idx;
  logic [SLOT_W-1:0]               probe_cnt;
  logic [lphs_pkg::CNT_W-1:0]      count;
  logic                            res_present;
  logic                            res_status;
  logic [lphs_pkg::SIZE_W-1:0]     size_log2;
  logic [lphs_pkg::LIMIT_W-1:0]    load_limit;
  logic [lphs_pkg::OUT_W-1:0]      out_data;

  logic [4:0]                      size_eff;
  logic [SLOT_W-1:0]               mask;
  logic [LIM_W-1:0]                limit_eff;
  logic                            at_limit;

  logic                            mix_start;
  lphs_pkg::mix_stat_t             mix_stat;
  logic [lphs_pkg::KEY_W-1:0]      mix_hash;

  logic                            ram_we;
  logic [SLOT_W-1:0]               ram_addr;
  logic [RAM_W-1:0]                ram_wdata;
  logic [RAM_W-1:0]                ram_rdata;
  logic                            slot_used;
  logic                            key_hit;

  // Slots in use, saturated between 16 and MAX_SLOTS, as an index mask
  always_comb begin
    size_eff = {1'b0, size_log2};
    if (size_eff < lphs_pkg::SIZE_LOG2_MIN) begin
      size_eff = lphs_pkg::SIZE_LOG2_MIN;
    end else if (size_eff > 5'(SLOT_W)) begin
      size_eff = 5'(SLOT_W);
    end
    for (int b = 0; b < SLOT_W; b++) begin
      mask[b] = (5'(b) < size_eff);
    end
  end

  // Load limit, saturated to one below the slots in use
  always_comb begin
    limit_eff = (LIM_W'(load_limit) > LIM_W'(mask)) ? LIM_W'(mask) : LIM_W'(load_limit);
    at_limit  = (LIM_W'(count) >= limit_eff);
  end

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  // Start the mix only for operations that probe the table
  assign mix_start = s_tvalid && s_tready &&
                     ((s_tuser == lphs_pkg::FUNC_INSERT) ||
                      (s_tuser == lphs_pkg::FUNC_EXISTS));

  lphs_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .start (mix_start),
    .key   (s_tdata),
    .stat  (mix_stat),
    .hash  (mix_hash)
  );

  // Table port: sweep while clearing, probe index otherwise
  always_comb begin
    ram_we    = (state == ST_CLEAR) || (state == ST_WRITE);
    ram_addr  = (state == ST_CLEAR) ? sweep : idx;
    ram_wdata = (state == ST_CLEAR) ? '0 : {1'b1, key_q};
  end

  lphs_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign slot_used = ram_rdata[lphs_pkg::KEY_W];
  assign key_hit   = (ram_rdata[lphs_pkg::KEY_W-1:0] == key_q);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2  <= lphs_pkg::SIZE_LOG2_RST;
      load_limit <= lphs_pkg::LOAD_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lphs_pkg::CFG_SIZE_LOG2:  size_log2  <= cfg_data[lphs_pkg::SIZE_W-1:0];
        lphs_pkg::CFG_LOAD_LIMIT: load_limit <= cfg_data[lphs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Operation sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      sweep    <= '0;
      clear_op <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the result once it is transferred, unless the next one loads now
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SLOT_W'(MAX_SLOTS - 1)) begin
            state <= clear_op ? ST_RESP : ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            func_q      <= s_tuser;
            key_q       <= s_tdata;
            res_present <= 1'b0;
            res_status  <= 1'b0;
            clear_op    <= 1'b0;
            case (s_tuser)
              lphs_pkg::FUNC_INSERT,
              lphs_pkg::FUNC_EXISTS: state <= ST_HASH;
              lphs_pkg::FUNC_CLEAR: begin
                clear_op <= 1'b1;
                sweep    <= '0;
                count    <= '0;
                state    <= ST_CLEAR;
              end
              default: state <= ST_RESP;
            endcase
          end
        end

        ST_HASH: begin
          if (mix_stat.done) begin
            idx       <= mix_hash[SLOT_W-1:0] & mask;
            probe_cnt <= '0;
            state     <= ST_RD;
          end
        end

        ST_RD: begin
          state <= ST_CMP;
        end

        ST_CMP: begin
          if (!slot_used) begin
            // Free slot ends the probe
            if (func_q == lphs_pkg::FUNC_INSERT) begin
              if (at_limit) begin
                res_status <= 1'b1;
                state      <= ST_RESP;
              end else begin
                state <= ST_WRITE;
              end
            end else begin
              state <= ST_RESP;
            end
          end else if (key_hit) begin
            res_present <= 1'b1;
            state       <= ST_RESP;
          end else if (probe_cnt == mask) begin
            // Every slot in use visited without a free one
            res_status <= (func_q == lphs_pkg::FUNC_INSERT);
            state      <= ST_RESP;
          end else begin
            idx       <= (idx + 1'b1) & mask;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= ST_RD;
          end
        end

        ST_WRITE: begin
          count <= count + 1'b1;
          state <= ST_RESP;
        end

        ST_RESP: begin
          // Load the result register once it is free
          if (!m_tvalid || m_tready) begin
            out_data <= {{(lphs_pkg::OUT_W - lphs_pkg::CNT_W - 2){1'b0}},
                         count, res_status, res_present};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = out_data;

  // Checks
  `LPHS_ASSERT_NOW(a_write_below_limit, (state == ST_WRITE), (LIM_W'(count) < limit_eff), "insert writes a new key at or above the load limit")
  `LPHS_ASSERT_NOW(a_write_in_range, (state == ST_WRITE), ((idx & ~mask) == '0), "insert writes outside the slots in use")
  `LPHS_ASSERT_NOW(a_probe_bounded, (state == ST_CMP), (probe_cnt <= mask), "probe ran past the slots in use")
  `LPHS_ASSERT_NOW(a_clear_count, (state == ST_CLEAR), (count == '0), "count not zero while the table is swept")
  `LPHS_ASSERT_NOW(a_mix_idle, (state != ST_HASH), (!mix_stat.busy), "mix unit busy outside the hash phase")
  `LPHS_ASSERT_NEXT(a_resp_hold, (state == ST_RESP && m_tvalid && !m_tready), (state == ST_RESP), "result register overwritten while stalled")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the linear probing hash set core. A queue of pending
// operations (directed corners, then random phases under several table sizes
// and load limits) feeds a bursty driver. A clocked monitor predicts each
// accepted operation against its own copy of the table and compares every
// returned result field by field. The receiver stalls on a rotating pattern
// and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import lphs_pkg::*;

  localparam int MAX_SLOTS     = 1024;
  localparam int MAX_LOG2      = $clog2(MAX_SLOTS);
  localparam int MIN_SLOTS     = 1 << SIZE_LOG2_MIN;
  localparam int SETTLE_CYCLES = 16;
  localparam int PRESSURE_HOLD = 400;
  localparam int ITEM_CYCLES   = 2 * MAX_SLOTS + 150;
  localparam int CYCLE_LIMIT   = 4 * 850 * ITEM_CYCLES;

  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } set_op_t;

  // same layout as m_tdata[11:0]
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             status;
    logic             present;
  } set_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [KEY_W-1:0]      s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_op_t       pending_ops[$];
  set_result_t   expected_results[$];
  logic [63:0]   key_pool[$];
  int            err_cnt = 0;
  logic          s_taken = 1'b0;
  logic          pressure_on = 1'b0;

  // Model of the table
  logic [KEY_W-1:0] stored_keys [MAX_SLOTS];
  bit               slot_used [MAX_SLOTS];
  logic [CNT_W-1:0] key_count;
  logic [SIZE_W-1:0] cur_size_log2;
  logic [LIMIT_W-1:0] cur_load_limit;

  linear_probe_hash_set_core #(
    .MAX_SLOTS(MAX_SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Home-slot mix of a key, all right shifts logical
  function automatic logic [63:0] key_mix(input logic [63:0] v);
    logic [63:0] h;
    h = ~v + (v << 21);
    h = h ^ (h >> 24);
    h = h + (h << 3) + (h << 8);
    h = h ^ (h >> 14);
    h = h + (h << 2) + (h << 4);
    h = h ^ (h >> 28);
    h = h + (h << 31);
    return h;
  endfunction

  // Apply one operation to the table model and return its result
  function automatic set_result_t apply_set_op(input logic [FUNC_W-1:0] fn,
                                               input logic [KEY_W-1:0] k);
    set_result_t r;
    int slots;
    int mask;
    int idx;
    int lim;
    int n;
    bit hit;
    bit got_free;
    r = '0;
    if (int'(cur_size_log2) >= MAX_LOG2) slots = MAX_SLOTS;
    else slots = 1 << cur_size_log2;
    if (slots < MIN_SLOTS) slots = MIN_SLOTS;
    mask = slots - 1;
    hit = 1'b0;
    got_free = 1'b0;
    if (fn == FUNC_INSERT || fn == FUNC_EXISTS) begin
      idx = int'(key_mix(k) & 64'(mask));
      // walk forward until a hit, a free slot, or every slot in use was seen
      for (n = 0; n < slots && !hit && !got_free; n++) begin
        if (!slot_used[idx]) got_free = 1'b1;
        else if (stored_keys[idx] == k) hit = 1'b1;
        else idx = (idx + 1) & mask;
      end
    end
    case (fn)
      FUNC_INSERT: begin
        lim = int'(cur_load_limit);
        if (lim > slots - 1) lim = slots - 1;
        if (hit) begin
          r.present = 1'b1;
        end else if (int'(key_count) >= lim || !got_free) begin
          r.status = 1'b1;
        end else begin
          stored_keys[idx] = k;
          slot_used[idx] = 1'b1;
          key_count = key_count + 1'b1;
        end
      end
      FUNC_EXISTS: r.present = hit;
      FUNC_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        key_count = '0;
      end
      default: ;
    endcase
    r.count = key_count;
    return r;
  endfunction

  // Mix of pool hits, small values, corner patterns and fresh random keys
  function automatic logic [63:0] draw_key();
    logic [63:0] k;
    int r;
    r = $urandom_range(99);
    if (r < 45 && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else if (r < 55) begin
      k = 64'($urandom_range(31));
    end else if (r < 60) begin
      case ($urandom_range(3))
        0: k = '0;
        1: k = '1;
        2: k = {1'b1, 63'b0};
        default: k = {1'b0, {63{1'b1}}};
      endcase
    end else begin
      k = {$urandom, $urandom};
    end
    if (r >= 45 || key_pool.size() == 0) begin
      key_pool.push_back(k);
      if (key_pool.size() > 48) void'(key_pool.pop_front());
    end
    return k;
  endfunction

  task automatic push_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k);
    set_op_t op;
    op.func = fn;
    op.key = k;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(input int n, input int ins_pct, input bit with_clear);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < ins_pct) push_op(FUNC_INSERT, draw_key());
      else if (with_clear && r >= 98) push_op(FUNC_CLEAR, draw_key());
      else if (r >= 95) push_op(FUNC_UNUSED, draw_key());
      else push_op(FUNC_EXISTS, draw_key());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every operation was taken and answered, then let the core settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] sz, input logic [LIMIT_W-1:0] lim,
                           input bit clear_first, input int n, input int ins_pct,
                           input bit with_clear);
    // upper bits of a size write are don't-care
    write_reg(CFG_SIZE_LOG2, {6'($urandom_range(63)), sz});
    write_reg(CFG_LOAD_LIMIT, lim);
    if (clear_first) push_op(FUNC_CLEAR, draw_key());
    queue_random(n, ins_pct, with_clear);
    wait_idle();
  endtask

  // Driver: present queued operations in bursts separated by random gaps
  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk) begin : drive_ops
    set_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_taken) begin
      // hold the current transfer until it is taken
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_ops.size() > 0) begin
      op = pending_ops.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= op.key;
      s_tuser <= op.func;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: rotating stall pattern, renewed when pat_age wraps; one long hold
  logic [15:0] ready_pat = 16'hffff;
  int          pat_age = 0;
  int          hold_cycles = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (pressure_on && !hold_done) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == PRESSURE_HOLD - 1) hold_done <= 1'b1;
    end else begin
      m_tready <= ready_pat[0];
      if (pat_age == 63) begin
        ready_pat <= ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
        pat_age <= 0;
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
        pat_age <= pat_age + 1;
      end
    end
  end

  // Monitor: track config, predict accepted operations, check results
  always @(posedge clk) begin : watch_ports
    set_result_t got;
    set_result_t want;
    if (rst) begin
      s_taken <= 1'b0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      key_count = '0;
      cur_size_log2 = SIZE_LOG2_RST;
      cur_load_limit = LOAD_LIMIT_RST;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SIZE_LOG2) cur_size_log2 = cfg_data[SIZE_W-1:0];
        else if (cfg_index == CFG_LOAD_LIMIT) cur_load_limit = cfg_data[LIMIT_W-1:0];
      end
      if (s_tvalid && s_tready) expected_results.push_back(apply_set_op(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = set_result_t'(m_tdata[11:0]);
        if (expected_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] result with nothing pending: present=%0b status=%0b count=%0d",
                     $time, got.present, got.status, got.count);
        end else begin
          want = expected_results.pop_front();
          if (got.present != want.present || got.status != want.status ||
              got.count != want.count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] mismatch: exp present=%0b status=%0b count=%0d, got present=%0b status=%0b count=%0d",
                       $time, want.present, want.status, want.count,
                       got.present, got.status, got.count);
          end
        end
      end
    end
  end

  // Timeout
  initial begin : watchdog
    int c;
    for (c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("** linear_probe_hash_set_core: FAILED **");
    $finish;
  end

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners under reset configuration
    push_op(FUNC_INSERT, 64'h0);
    push_op(FUNC_INSERT, '1);
    push_op(FUNC_INSERT, 64'h8000_0000_0000_0000);
    push_op(FUNC_INSERT, 64'h7fff_ffff_ffff_ffff);
    push_op(FUNC_INSERT, 64'h0);
    push_op(FUNC_EXISTS, '1);
    push_op(FUNC_EXISTS, 64'h1);
    push_op(FUNC_EXISTS, 64'h8000_0000_0000_0000);
    push_op(FUNC_UNUSED, {$urandom, $urandom});
    push_op(FUNC_CLEAR, {$urandom, $urandom});
    push_op(FUNC_EXISTS, 64'h0);
    push_op(FUNC_INSERT, 64'h7fff_ffff_ffff_ffff);
    push_op(FUNC_INSERT, 64'h7fff_ffff_ffff_ffff);
    wait_idle();

    // smallest table, limit saturated to one below the size: fills up
    run_phase(4'd4, 10'd1023, 1'b1, 110, 60, 1'b0);
    // size below range saturates to the smallest table
    run_phase(4'd0, 10'd5, 1'b1, 50, 55, 1'b1);
    // size above range saturates to the full table; limit of one
    run_phase(4'd15, 10'd1, 1'b1, 30, 50, 1'b0);
    // zero limit refuses every new key
    run_phase(4'd8, 10'd0, 1'b0, 25, 60, 1'b0);
    run_phase(4'd6, 10'd40, 1'b1, 100, 55, 1'b1);
    // fill a 32-slot table, then shrink without a clear
    run_phase(4'd5, 10'd1023, 1'b1, 70, 100, 1'b0);
    run_phase(4'd4, 10'd1023, 1'b0, 60, 40, 1'b0);
    run_phase(4'd7, 10'd100, 1'b0, 90, 50, 1'b1);
    // receiver holds off long enough to stall the input
    pressure_on = 1'b1;
    run_phase(4'd9, 10'd300, 1'b0, 80, 50, 1'b0);
    run_phase(4'd11, 10'd1000, 1'b1, 40, 60, 1'b0);
    run_phase(4'd10, 10'd716, 1'b1, 150, 55, 1'b1);

    repeat (40) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("** linear_probe_hash_set_core: PASSED **");
    end else begin
      $display("** linear_probe_hash_set_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== linear_probe_hash_set_core.f =====
+incdir+rtl
rtl/lphs_pkg.sv
rtl/lphs_ram.sv
rtl/lphs_mix.sv
rtl/linear_probe_hash_set_core.sv
dv/tb_top.sv
